// File: rtl/csl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset lexer package
// Token and error codes, the result record and shared constants.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 255;
	localparam int COLUMN_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH       = 4;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int KW_BUF_LEN        = 6;

	localparam logic [15:0] FIRST_LINE_RST   = 16'd1;
	localparam logic [15:0] FIRST_COLUMN_RST = 16'd0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FIRST_LINE   = 2'd0,
		CFG_FIRST_COLUMN = 2'd1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		TK_RETURN  = 5'd0,
		TK_INT     = 5'd1,
		TK_EXIT    = 5'd2,
		TK_IF      = 5'd3,
		TK_IDENT   = 5'd4,
		TK_LITERAL = 5'd5,
		TK_ASSIGN  = 5'd6,
		TK_EQ      = 5'd7,
		TK_LPAREN  = 5'd8,
		TK_RPAREN  = 5'd9,
		TK_LBRACE  = 5'd10,
		TK_RBRACE  = 5'd11,
		TK_SEMI    = 5'd12,
		TK_PLUS    = 5'd13,
		TK_INCR    = 5'd14,
		TK_MINUS   = 5'd15,
		TK_DECR    = 5'd16,
		TK_STAR    = 5'd17,
		TK_SLASH   = 5'd18,
		TK_ERROR   = 5'd19
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_BAD_CHR = 2'd1,
		ERR_BAD_RUN = 2'd2
	} err_kind_t;

	// Byte 0 holds the first character of the pending token.
	typedef logic [KW_BUF_LEN-1:0][7:0] kw_buf_t;

	localparam kw_buf_t KW_RETURN = {"n", "r", "u", "t", "e", "r"};
	localparam kw_buf_t KW_INT    = {8'h00, 8'h00, 8'h00, "t", "n", "i"};
	localparam kw_buf_t KW_EXIT   = {8'h00, 8'h00, "t", "i", "x", "e"};
	localparam kw_buf_t KW_IF     = {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"};

	typedef struct packed {
		tok_kind_t   kind;
		err_kind_t   err;
		logic [15:0] line;
		logic [23:0] col;
		logic [7:0]  len;
		logic        ovf;
		logic        last;
	} csl_result_t;

	// Up to two results per character; a single result always uses slot 0.
	typedef struct packed {
		logic        v0;
		logic        v1;
		csl_result_t r0;
		csl_result_t r1;
	} csl_push_t;

endpackage

// File: rtl/csl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset lexer core
// Holds the pending token and counters and turns one character into up to
// two results combinationally.
// ----------------------------------------------------------------------------
module csl_core #(
	parameter int MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF,
	parameter int COLUMN_BITS   = csl_pkg::COLUMN_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         ch,
	input  logic               last_char,
	input  logic [15:0]        first_line,
	input  logic [15:0]        first_column,
	output csl_pkg::csl_push_t push
);
	import csl_pkg::*;

	localparam int RUN_BITS = $clog2(MAX_TOKEN_LEN + 2);
	localparam int LEN_CAP  = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
	localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_IDENT = 3'd1,
		CLS_LIT   = 3'd2,
		CLS_EQ    = 3'd3,
		CLS_PLUS  = 3'd4,
		CLS_MINUS = 3'd5
	} cls_t;

	typedef struct packed {
		tok_kind_t kind;
		err_kind_t err;
		logic      halt;
	} flush_t;

	cls_t                  cls_q;
	logic [RUN_BITS-1:0]   run_q;
	kw_buf_t               buf_q;
	logic [15:0]           line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic                  halted_q;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {["0":"9"]});
	endfunction

	function automatic logic continues(input cls_t cls, input logic [7:0] c);
		logic r;
		case (cls)
			CLS_IDENT: r = is_alpha(c) || is_digit(c) || (c == "_");
			CLS_LIT:   r = is_digit(c);
			CLS_EQ:    r = (c == "=");
			CLS_PLUS:  r = (c == "+");
			CLS_MINUS: r = (c == "-");
			default:   r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic flush_t run_token(input logic [RUN_BITS-1:0] run,
			input tok_kind_t one, input tok_kind_t two);
		flush_t f;
		f.halt = 1'b0;
		f.err  = ERR_NONE;
		if (run == RUN_BITS'(1)) begin
			f.kind = one;
		end else if (run == RUN_BITS'(2)) begin
			f.kind = two;
		end else begin
			f.kind = TK_ERROR;
			f.err  = ERR_BAD_RUN;
			f.halt = 1'b1;
		end
		return f;
	endfunction

	function automatic flush_t flush_eval(input cls_t cls, input logic [RUN_BITS-1:0] run,
			input kw_buf_t b);
		flush_t f;
		f.kind = TK_IDENT;
		f.err  = ERR_NONE;
		f.halt = 1'b0;
		case (cls)
			CLS_IDENT: begin
				if (run == RUN_BITS'(6) && b == KW_RETURN) f.kind = TK_RETURN;
				else if (run == RUN_BITS'(3) && b == KW_INT) f.kind = TK_INT;
				else if (run == RUN_BITS'(4) && b == KW_EXIT) f.kind = TK_EXIT;
				else if (run == RUN_BITS'(2) && b == KW_IF) f.kind = TK_IF;
				else f.kind = TK_IDENT;
			end
			CLS_LIT:   f.kind = TK_LITERAL;
			CLS_EQ:    f = run_token(run, TK_ASSIGN, TK_EQ);
			CLS_PLUS:  f = run_token(run, TK_PLUS, TK_INCR);
			CLS_MINUS: f = run_token(run, TK_MINUS, TK_DECR);
			default:   f.kind = TK_IDENT;
		endcase
		return f;
	endfunction

	function automatic csl_result_t make_res(input tok_kind_t kind, input err_kind_t err,
			input logic [15:0] line, input logic [COLUMN_BITS-1:0] col,
			input logic [RUN_BITS-1:0] count);
		csl_result_t r;
		logic [31:0] col32;
		col32  = 32'(col);
		r.kind = kind;
		r.err  = err;
		r.line = line;
		r.col  = (col32 > 32'h00FF_FFFF) ? 24'hFF_FFFF : col32[23:0];
		r.ovf  = (count > RUN_BITS'(LEN_CAP));
		r.len  = r.ovf ? 8'(LEN_CAP) : 8'(count);
		r.last = 1'b0;
		return r;
	endfunction

	// Character decode for a character that starts fresh.
	cls_t      fcls;
	logic      is_single, is_nl, is_ws, is_bad;
	tok_kind_t single_kind;

	always_comb begin
		fcls        = CLS_NONE;
		is_single   = 1'b0;
		is_nl       = 1'b0;
		is_ws       = 1'b0;
		is_bad      = 1'b0;
		single_kind = TK_LPAREN;
		if (is_alpha(ch) || ch == "_") begin
			fcls = CLS_IDENT;
		end else if (is_digit(ch)) begin
			fcls = CLS_LIT;
		end else begin
			case (ch)
				"=":   fcls = CLS_EQ;
				"+":   fcls = CLS_PLUS;
				"-":   fcls = CLS_MINUS;
				"(": begin is_single = 1'b1; single_kind = TK_LPAREN; end
				")": begin is_single = 1'b1; single_kind = TK_RPAREN; end
				"{": begin is_single = 1'b1; single_kind = TK_LBRACE; end
				"}": begin is_single = 1'b1; single_kind = TK_RBRACE; end
				";": begin is_single = 1'b1; single_kind = TK_SEMI; end
				"*": begin is_single = 1'b1; single_kind = TK_STAR; end
				"/": begin is_single = 1'b1; single_kind = TK_SLASH; end
				8'h0A: is_nl = 1'b1;
				8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: is_ws = 1'b1;
				default: is_bad = 1'b1;
			endcase
		end
	end

	logic                   cont, emit_a, emit_b, emit_c, halt1, fresh_ok;
	flush_t                 f1, f2;
	cls_t                   ncls;
	logic [RUN_BITS-1:0]    nrun, run_ext;
	kw_buf_t                nbuf, buf_ext, buf_new;
	logic [COLUMN_BITS-1:0] col_inc, col_n;
	logic [15:0]            line_n;
	csl_result_t            res_a, res_b, res_c;

	always_comb begin
		cont     = (cls_q != CLS_NONE) && continues(cls_q, ch);
		f1       = flush_eval(cls_q, run_q, buf_q);
		emit_a   = !halted_q && !cont && (cls_q != CLS_NONE);
		halt1    = emit_a && f1.halt;
		fresh_ok = !halted_q && !cont && !halt1;

		for (int i = 0; i < KW_BUF_LEN; i++) begin
			buf_ext[i] = (run_q == RUN_BITS'(i)) ? ch : buf_q[i];
			buf_new[i] = (i == 0) ? ch : 8'h00;
		end
		run_ext = (run_q <= RUN_BITS'(MAX_TOKEN_LEN)) ? run_q + 1'b1 : run_q;

		if (cont) begin
			ncls = cls_q;
			nrun = run_ext;
			nbuf = buf_ext;
		end else if (fresh_ok && fcls != CLS_NONE) begin
			ncls = fcls;
			nrun = RUN_BITS'(1);
			nbuf = buf_new;
		end else begin
			ncls = CLS_NONE;
			nrun = '0;
			nbuf = '0;
		end

		col_inc = (col_q == COL_MAX) ? col_q : col_q + 1'b1;
		col_n   = (!halted_q && (cont || (fresh_ok && !is_bad))) ? col_inc : col_q;
		line_n  = (fresh_ok && is_nl && line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;

		emit_b = fresh_ok && (is_single || is_bad);
		f2     = flush_eval(ncls, nrun, nbuf);
		emit_c = !halted_q && last_char && !halt1 && !(fresh_ok && is_bad) &&
			(ncls != CLS_NONE);

		res_a = make_res(f1.kind, f1.err, line_q, col_q, run_q);
		res_b = is_bad ? make_res(TK_ERROR, ERR_BAD_CHR, line_q, col_q, RUN_BITS'(1))
			: make_res(single_kind, ERR_NONE, line_q, col_q, RUN_BITS'(1));
		res_c = make_res(f2.kind, f2.err, line_q, col_n, nrun);

		// Results B and C never occur together, so at most two go out.
		push.v0 = step && (emit_a || emit_b || emit_c);
		push.v1 = step && emit_a && (emit_b || emit_c);
		push.r0 = emit_a ? res_a : (emit_b ? res_b : res_c);
		push.r1 = emit_b ? res_b : res_c;
		push.r0.last = !(emit_a && (emit_b || emit_c));
		push.r1.last = 1'b1;
	end

	logic [COLUMN_BITS-1:0] col_start;
	assign col_start = (32'(first_column) > 32'(COL_MAX)) ? COL_MAX
		: COLUMN_BITS'(first_column);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q    <= CLS_NONE;
			run_q    <= '0;
			buf_q    <= '0;
			line_q   <= FIRST_LINE_RST;
			col_q    <= COLUMN_BITS'(FIRST_COLUMN_RST);
			halted_q <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				cls_q    <= CLS_NONE;
				run_q    <= '0;
				buf_q    <= '0;
				line_q   <= first_line;
				col_q    <= col_start;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				cls_q    <= ncls;
				run_q    <= nrun;
				buf_q    <= nbuf;
				line_q   <= line_n;
				col_q    <= col_n;
				halted_q <= halt1 || (fresh_ok && is_bad);
			end
		end
	end

endmodule

// File: rtl/csl_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset lexer result queue
// Small queue that takes up to two results a cycle and hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module csl_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csl_pkg::csl_push_t   push,
	output logic                 room2,
	output logic                 out_valid,
	input  logic                 out_ready,
	output csl_pkg::csl_result_t head
);
	import csl_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	csl_result_t   mem_q [QUEUE_DEPTH];
	logic [PW-1:0] rd_q, wr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [1:0]    npush;

	assign room2     = (cnt_q <= CW'(QUEUE_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	assign npush     = {1'b0, push.v0} + {1'b0, push.v1};

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.r0;
		if (push.v1) mem_q[PW'(wr_q + 1'b1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(npush);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(npush) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("result queue holds more than its depth");

	a_pair_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> cnt_q <= CW'(QUEUE_DEPTH - 2))
		else $error("two results pushed without room for both");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0)
		else $error("second result slot used without the first");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!push.v0 && pop) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not drop after a pop");

endmodule

// File: rtl/c_subset_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset lexer unit
// Maximal munch tokenizer taking one source character per request.
// ----------------------------------------------------------------------------
// Path: a result reaches the master side through the input register, then
// the lexer step into the result queue.
// Throughput: one character per cycle while each gives at most one result and
// the master side keeps up; a character that gives two results hands them out one after the other,
// absorbed by the four-entry result queue, and input stalls while the queue holds over two.
// Reset clears the lexer state, loads line 1 and column 0, and empties the queue.
module c_subset_lexer_unit #(
	parameter int MAX_TOKEN_LEN = csl_pkg::MAX_TOKEN_LEN_DEF,
	parameter int COLUMN_BITS   = csl_pkg::COLUMN_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] ch
	input  logic                               s_tlast,   // last_char
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] line_no, [39:16] column_no, [47:40] token_length,
	// [48] length_overflow, [55:49] zero
	output logic [55:0]                        m_tdata,
	output logic [6:0]                         m_tuser,   // [4:0] token_kind, [6:5] error_kind
	output logic                               m_tlast,   // last_result
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [15:0]                        cfg_data
);
	import csl_pkg::*;

	logic        valid_s1, last_s1;
	logic [7:0]  ch_s1;
	logic [15:0] first_line_q, first_column_q;
	logic        room2, fire;
	csl_push_t   push;
	csl_result_t head;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || room2;
	assign fire      = valid_s1 && room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q   <= FIRST_LINE_RST;
			first_column_q <= FIRST_COLUMN_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FIRST_LINE:   first_line_q   <= cfg_data;
				CFG_FIRST_COLUMN: first_column_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	csl_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.COLUMN_BITS  (COLUMN_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (fire),
		.ch          (ch_s1),
		.last_char   (last_s1),
		.first_line  (first_line_q),
		.first_column(first_column_q),
		.push        (push)
	);

	csl_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room2    (room2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.head     (head)
	);

	assign m_tdata = {7'b0, head.ovf, head.len, head.col, head.line};
	assign m_tuser = {head.err, head.kind};
	assign m_tlast = head.last;

endmodule
